FILE: hdl/cgb_pkg.sv
// Shared types and constants for the clipped glyph blit unit.
package cgb_pkg;

   // Glyph rows are one byte wide, most significant bit leftmost
   localparam int GLYPH_WIDTH = 8;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_DRAW = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      CSR_CLIP_LEFT   = 3'd0,
      CSR_CLIP_TOP    = 3'd1,
      CSR_CLIP_RIGHT  = 3'd2,
      CSR_CLIP_BOTTOM = 3'd3,
      CSR_FORE_COLOUR = 3'd4,
      CSR_BACK_COLOUR = 3'd5,
      CSR_LINE_STRIDE = 3'd6,
      CSR_FRAME_BASE  = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLIP,
      ST_TEST,
      ST_BASE,
      ST_READ,
      ST_PIX
   } state_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         char_code;
      logic [2:0]         glyph_row;
      logic [7:0]         row_bits;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_addr;
      logic [7:0]  pixel_value;
      logic        last;
   } rsp_type;

endpackage

FILE: hdl/cgb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cgb_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hdl/clipped_glyph_blit_8bpp_unit.sv
// Clipped glyph blit: glyph store, clip sequencer and pixel write stream.
//
// Input channel req_*: one item per transfer. A load item (kind 0) writes one
// byte row of one glyph into the glyph store and produces nothing. A draw item
// (kind 1) clips the glyph cell at (pos_x, pos_y) against the clip rectangle
// and streams one pixel write per visible pixel on rsp_*, row-major, with
// last set on the final write. Fully clipped draws produce nothing.
// Configuration registers are written through csr_* (always ready); the user
// must write them only while the unit is idle, the block does not enforce it.
// A load is written straight into the glyph store. A draw holds the input
// channel through the setup states ST_CLIP (clip bounds), ST_TEST (empty test
// and row-address multiply; a fully clipped draw ends here) and ST_BASE (base
// add), then per visible row through one glyph store read followed by one
// pixel per cycle while the result side does not stall. The single-read glyph
// store port and the per-pixel output register set this rate. When rsp_stall
// is high the output register holds its pixel and the sequencer waits. Reset
// (synchronous) returns the sequencer to idle, drops any pending pixel and
// restores register defaults; glyph store contents are undefined until loaded.
module clipped_glyph_blit_8bpp_unit #(
   parameter int NUM_GLYPHS   = 256,
   parameter int GLYPH_HEIGHT = 8
) (
   input  logic                clock,
   input  logic                reset,
   // input channel
   input  logic                req_valid,
   output logic                req_stall,
   input  cgb_pkg::req_type    req_data,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cgb_pkg::rsp_type    rsp_data,
   // configuration port
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);

   import cgb_pkg::*;

   localparam int DEPTH  = NUM_GLYPHS * GLYPH_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_W  = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
   localparam int COL_W  = $clog2(GLYPH_WIDTH);

   // configuration registers
   logic signed [15:0] clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;
   logic [7:0]         fore_colour_ff, back_colour_ff;
   logic [15:0]        line_stride_ff;
   logic [31:0]        frame_base_ff;

   // sequencer and datapath registers
   state_type          state_ff, state_in;
   logic [7:0]         code_ff;
   logic signed [15:0] pos_x_ff, pos_y_ff;
   logic signed [16:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [COL_W-1:0]   col_ff, col_first_ff, col_last_ff;
   logic [ROW_W-1:0]   row_ff, row_last_ff;
   logic [31:0]        prod_ff;
   logic [31:0]        row_addr_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // control strobes
   logic               req_xfer, rsp_free, pix_load, is_empty;
   logic               code_ok, load_ok, start_draw, row_end, cell_end;

   // glyph store ports
   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [7:0]         ram_rd_data;

   // clip combinational values
   logic signed [16:0] px_ext, py_ext, x0_in, x1_in, y0_in, y1_in;
   logic signed [16:0] px_end, py_end;
   logic signed [32:0] prod_full;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Decode handshakes
   assign req_xfer   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign code_ok    = {1'b0, req_data.char_code} < 9'(NUM_GLYPHS);
   assign load_ok    = code_ok && ({2'b00, req_data.glyph_row} < 5'(GLYPH_HEIGHT));
   assign start_draw = req_xfer && (req_data.kind == KIND_DRAW) && code_ok;
   assign row_end    = (col_ff == col_last_ff);
   assign cell_end   = row_end && (row_ff == row_last_ff);
   assign is_empty   = (x0_ff >= x1_ff) || (y0_ff >= y1_ff);

   // Clip bounds from the captured position
   assign px_ext = 17'(pos_x_ff);
   assign py_ext = 17'(pos_y_ff);
   assign px_end = px_ext + 17'(GLYPH_WIDTH);
   assign py_end = py_ext + 17'(GLYPH_HEIGHT);
   assign x0_in  = (px_ext > 17'(clip_left_ff))   ? px_ext : 17'(clip_left_ff);
   assign x1_in  = (px_end < 17'(clip_right_ff))  ? px_end : 17'(clip_right_ff);
   assign y0_in  = (py_ext > 17'(clip_top_ff))    ? py_ext : 17'(clip_top_ff);
   assign y1_in  = (py_end < 17'(clip_bottom_ff)) ? py_end : 17'(clip_bottom_ff);

   // Top row times stride, modulo 2^32
   assign prod_full = y0_ff * $signed({1'b0, line_stride_ff});

   // Glyph store addressing
   assign ram_wr_addr = ADDR_W'(req_data.char_code) * ADDR_W'(GLYPH_HEIGHT)
                        + ADDR_W'(req_data.glyph_row);
   assign ram_rd_addr = ADDR_W'(code_ff) * ADDR_W'(GLYPH_HEIGHT) + ADDR_W'(row_ff);

   cgb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_glyph_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.row_bits),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_draw) begin
               state_in = ST_CLIP;
            end
         end
         ST_CLIP: state_in = ST_TEST;
         ST_TEST: state_in = is_empty ? ST_IDLE : ST_BASE;
         ST_BASE: state_in = ST_READ;
         ST_READ: state_in = ST_PIX;
         ST_PIX: begin
            if (rsp_free && row_end) begin
               state_in = cell_end ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      pix_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ram_wr_en = req_xfer && (req_data.kind == KIND_LOAD) && load_ok;
         end
         ST_READ: ram_rd_en = 1'b1;
         ST_PIX:  pix_load  = rsp_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Advance state, drop pending pixel on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pix_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= 16'sd0;
         clip_top_ff    <= 16'sd0;
         clip_right_ff  <= 16'sd640;
         clip_bottom_ff <= 16'sd480;
         fore_colour_ff <= 8'd255;
         back_colour_ff <= 8'd0;
         line_stride_ff <= 16'd640;
         frame_base_ff  <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CLIP_LEFT:   clip_left_ff   <= csr_data[15:0];
            CSR_CLIP_TOP:    clip_top_ff    <= csr_data[15:0];
            CSR_CLIP_RIGHT:  clip_right_ff  <= csr_data[15:0];
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_data[15:0];
            CSR_FORE_COLOUR: fore_colour_ff <= csr_data[7:0];
            CSR_BACK_COLOUR: back_colour_ff <= csr_data[7:0];
            CSR_LINE_STRIDE: line_stride_ff <= csr_data[15:0];
            CSR_FRAME_BASE:  frame_base_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // capture a draw item
      if (start_draw) begin
         code_ff  <= req_data.char_code;
         pos_x_ff <= req_data.pos_x;
         pos_y_ff <= req_data.pos_y;
      end
      // clip bounds
      if (state_ff == ST_CLIP) begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         y0_ff <= y0_in;
         y1_ff <= y1_in;
      end
      // cell offsets and row multiply
      if (state_ff == ST_TEST) begin
         col_first_ff <= COL_W'(x0_ff - px_ext);
         col_ff       <= COL_W'(x0_ff - px_ext);
         col_last_ff  <= COL_W'(x1_ff - px_ext - 17'sd1);
         row_ff       <= ROW_W'(y0_ff - py_ext);
         row_last_ff  <= ROW_W'(y1_ff - py_ext - 17'sd1);
         prod_ff      <= prod_full[31:0];
      end
      // first row address, includes the cell's left edge
      if (state_ff == ST_BASE) begin
         row_addr_ff <= frame_base_ff + prod_ff + 32'(pos_x_ff);
      end
      // emit one pixel, then step column or row
      if (pix_load) begin
         rsp_ff.pixel_addr  <= row_addr_ff + 32'(col_ff);
         rsp_ff.pixel_value <= ram_rd_data[3'(GLYPH_WIDTH - 1) - col_ff]
                               ? fore_colour_ff : back_colour_ff;
         rsp_ff.last        <= cell_end;
         if (row_end) begin
            col_ff      <= col_first_ff;
            row_ff      <= row_ff + ROW_W'(1);
            row_addr_ff <= row_addr_ff + 32'(line_stride_ff);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // Column offset stays inside the clipped span while pixels stream
   a_col_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |-> (col_ff >= col_first_ff) && (col_ff <= col_last_ff))
      else $error("column offset left the clipped span");

   // Row offset never passes the last visible row
   a_row_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX || state_ff == ST_READ) |-> (row_ff <= row_last_ff))
      else $error("row offset passed the last visible row");

   // A draw sequence starts only from an accepted in-range draw transfer
   a_draw_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLIP) |-> $past(req_valid && !req_stall
                                      && req_data.kind == KIND_DRAW))
      else $error("draw started without a draw transfer");

   // The final pixel of a cell returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (pix_load && cell_end) |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_ff.last)
      else $error("last pixel did not end the draw");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the clipped glyph blit unit: glyph loads, clipped draws, pixel stream.
module testbench;
   import cgb_pkg::*;

   localparam int NUM_CODES     = 256;
   localparam int CELL_ROWS     = 8;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int NUM_PHASES    = 6;

   // register image of the unit, at the widths of the configuration port
   typedef struct packed {
      logic signed [15:0] clip_l;
      logic signed [15:0] clip_t;
      logic signed [15:0] clip_r;
      logic signed [15:0] clip_b;
      logic [7:0]         fore;
      logic [7:0]         back;
      logic [15:0]        stride;
      logic [31:0]        base;
   } blit_cfg_type;

   // one row of the directed table; typed rows carry their expectation written out
   typedef struct {
      req_type item;
      bit      typed;
      int      n_pix;
      rsp_type pix;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   csr_index_type    csr_index = CSR_CLIP_LEFT;
   logic [31:0]      csr_data = '0;

   // bench-side copy of the unit's state
   blit_cfg_type     blit_cfg;
   bit [7:0]         glyph_rows [NUM_CODES][CELL_ROWS];
   bit [7:0]         row_loaded [NUM_CODES];
   bit               code_ready [NUM_CODES];
   logic [7:0]       ready_codes [$];
   rsp_type          expected_pixels [$];
   stim_row_type     directed_rows [$];

   int               gap_pct;
   int               stall_pct;
   int               mismatches = 0;
   int               n_loads = 0;
   int               n_draws = 0;
   int               n_blank = 0;
   int               n_pixels = 0;
   int               cycle_count = 0;

   clipped_glyph_blit_8bpp_unit #(
      .NUM_GLYPHS  (NUM_CODES),
      .GLYPH_HEIGHT(CELL_ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stall the result side at random
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixel writes outstanding",
                  cycle_count, expected_pixels.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // compare each pixel transfer with the oldest expected write
   always @(posedge clock) begin : check_pixels
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel write: addr %h value %h last %b",
                        rsp_data.pixel_addr, rsp_data.pixel_value, rsp_data.last);
         end else begin
            want = expected_pixels.pop_front();
            n_pixels++;
            if (rsp_data.pixel_addr !== want.pixel_addr ||
                rsp_data.pixel_value !== want.pixel_value ||
                rsp_data.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel %0d: expected addr %h value %h last %b, got %h %h %b",
                           n_pixels, want.pixel_addr, want.pixel_value, want.last,
                           rsp_data.pixel_addr, rsp_data.pixel_value, rsp_data.last);
            end
         end
      end
   end

   // Work out the pixel writes of one draw: clip the cell, then walk it row-major.
   task automatic predict_glyph_draw(input req_type item);
      int px, py, cl, ct, cr, cb;
      int x_lo, x_hi, y_lo, y_hi, x, y;
      logic [7:0] bits;
      rsp_type pix;
      px = $signed(item.pos_x);
      py = $signed(item.pos_y);
      cl = $signed(blit_cfg.clip_l);
      ct = $signed(blit_cfg.clip_t);
      cr = $signed(blit_cfg.clip_r);
      cb = $signed(blit_cfg.clip_b);
      x_lo = (px > cl) ? px : cl;
      x_hi = (px + GLYPH_WIDTH < cr) ? px + GLYPH_WIDTH : cr;
      y_lo = (py > ct) ? py : ct;
      y_hi = (py + CELL_ROWS < cb) ? py + CELL_ROWS : cb;
      if (x_lo >= x_hi || y_lo >= y_hi) begin
         n_blank++;
         return;
      end
      for (y = y_lo; y < y_hi; y++) begin
         bits = glyph_rows[item.char_code][y - py];
         for (x = x_lo; x < x_hi; x++) begin
            // address wraps modulo 2^32, negative coordinates included
            pix.pixel_addr  = blit_cfg.base + 32'(y) * 32'(blit_cfg.stride) + 32'(x);
            pix.pixel_value = bits[GLYPH_WIDTH - 1 - (x - px)] ? blit_cfg.fore : blit_cfg.back;
            pix.last        = (y == y_hi - 1) && (x == x_hi - 1);
            expected_pixels.push_back(pix);
         end
      end
   endtask

   // Offer one item, with a random gap first, and account for it once transferred.
   task automatic send_item(input req_type item, input bit typed = 1'b0,
                            input int n_pix = 0, input rsp_type pix = '0);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (item.kind == KIND_LOAD) begin
         n_loads++;
         glyph_rows[item.char_code][item.glyph_row] = item.row_bits;
         row_loaded[item.char_code][item.glyph_row] = 1'b1;
         // a glyph may be drawn once all its rows hold known data
         if (row_loaded[item.char_code] == 8'hFF && !code_ready[item.char_code]) begin
            code_ready[item.char_code] = 1'b1;
            ready_codes.push_back(item.char_code);
         end
      end else begin
         n_draws++;
         if (!typed)
            predict_glyph_draw(item);
         else if (n_pix == 0)
            n_blank++;
         else
            expected_pixels.push_back(pix);
      end
   endtask

   // Hold the sender until every expected write has come, then let the unit settle.
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CLIP_LEFT:   blit_cfg.clip_l = value[15:0];
         CSR_CLIP_TOP:    blit_cfg.clip_t = value[15:0];
         CSR_CLIP_RIGHT:  blit_cfg.clip_r = value[15:0];
         CSR_CLIP_BOTTOM: blit_cfg.clip_b = value[15:0];
         CSR_FORE_COLOUR: blit_cfg.fore   = value[7:0];
         CSR_BACK_COLOUR: blit_cfg.back   = value[7:0];
         CSR_LINE_STRIDE: blit_cfg.stride = value[15:0];
         CSR_FRAME_BASE:  blit_cfg.base   = value;
         default: ;
      endcase
   endtask

   // Write the whole register set back to back, then drop the write strobe.
   task automatic apply_setting(input blit_cfg_type s);
      csr_put(CSR_CLIP_LEFT,   32'(s.clip_l));
      csr_put(CSR_CLIP_TOP,    32'(s.clip_t));
      csr_put(CSR_CLIP_RIGHT,  32'(s.clip_r));
      csr_put(CSR_CLIP_BOTTOM, 32'(s.clip_b));
      csr_put(CSR_FORE_COLOUR, 32'(s.fore));
      csr_put(CSR_BACK_COLOUR, 32'(s.back));
      csr_put(CSR_LINE_STRIDE, 32'(s.stride));
      csr_put(CSR_FRAME_BASE,  s.base);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_row(input kind_type k, input logic [7:0] code,
                                   input logic [2:0] grow, input logic [7:0] bits,
                                   input logic [15:0] x, input logic [15:0] y,
                                   input bit typed = 1'b0, input int n_pix = 0,
                                   input rsp_type pix = '0);
      stim_row_type row;
      row.item.kind      = k;
      row.item.char_code = code;
      row.item.glyph_row = grow;
      row.item.row_bits  = bits;
      row.item.pos_x     = x;
      row.item.pos_y     = y;
      row.typed          = typed;
      row.n_pix          = n_pix;
      row.pix            = pix;
      directed_rows.push_back(row);
   endfunction

   function automatic req_type random_item(input kind_type k, input logic [7:0] code);
      req_type item;
      item.kind      = k;
      item.char_code = code;
      item.glyph_row = 3'($urandom);
      item.row_bits  = 8'($urandom);
      item.pos_x     = 16'($urandom);
      item.pos_y     = 16'($urandom);
      return item;
   endfunction

   // Place a cell edge mostly across the clip bounds, sometimes anywhere.
   function automatic logic [15:0] pick_pos(input logic signed [15:0] lo,
                                            input logic signed [15:0] hi);
      int r, span;
      r    = $urandom_range(99);
      span = int'(hi) - int'(lo);
      if (r < 15)
         return 16'($urandom);
      if (r < 50)
         return 16'(int'(lo) + int'($urandom_range(17)) - 9);
      if (r < 85)
         return 16'(int'(hi) + int'($urandom_range(17)) - 9);
      if (span > GLYPH_WIDTH)
         return 16'(int'(lo) + int'($urandom_range(span - GLYPH_WIDTH)));
      return lo;
   endfunction

   // Mostly draws of fully loaded glyphs, with whole-glyph loads and stray row loads.
   task automatic run_phase(input int n_items);
      int sent, r, start, i;
      bit paused;
      logic [7:0] code;
      req_type item;
      sent   = 0;
      paused = 1'b0;
      while (sent < n_items) begin
         if (!paused && sent >= n_items / 2) begin
            drain_results(0);
            paused = 1'b1;
         end
         r = $urandom_range(99);
         if (r < 12 || ready_codes.size() == 0) begin
            code  = 8'($urandom);
            start = $urandom_range(CELL_ROWS - 1);
            for (i = 0; i < CELL_ROWS; i++) begin
               item = random_item(KIND_LOAD, code);
               item.glyph_row = 3'((start + i) % CELL_ROWS);
               send_item(item);
            end
            sent += CELL_ROWS;
         end else if (r < 22) begin
            send_item(random_item(KIND_LOAD, 8'($urandom)));
            sent++;
         end else begin
            item = random_item(KIND_DRAW,
                               ready_codes[$urandom_range(ready_codes.size() - 1)]);
            item.pos_x = pick_pos(blit_cfg.clip_l, blit_cfg.clip_r);
            item.pos_y = pick_pos(blit_cfg.clip_t, blit_cfg.clip_b);
            send_item(item);
            sent++;
         end
      end
   endtask

   initial begin
      blit_cfg_type plan [NUM_PHASES];
      int phase_items [NUM_PHASES];
      int phase_gap [NUM_PHASES];
      int phase_stall [NUM_PHASES];
      int l, t, p;

      // register values after reset
      blit_cfg  = '{16'sd0, 16'sd0, 16'sd640, 16'sd480, 8'hFF, 8'h00, 16'd640, 32'd0};
      gap_pct   = 35;
      stall_pct = 49;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset defaults: corner pixels, fully clipped cells, a whole cell and partly clipped cells.
      add_row(KIND_LOAD, 8'h00, 3'd7, 8'h01, 16'h8000, 16'h7FFF, 1'b1);
      add_row(KIND_LOAD, 8'hFF, 3'd0, 8'h80, 16'h7FFF, 16'h8000, 1'b1);
      add_row(KIND_LOAD, 8'hFF, 3'd7, 8'hFF, 16'hFFFF, 16'h0000, 1'b1);
      add_row(KIND_LOAD, 8'h00, 3'd0, 8'h00, 16'h0000, 16'hFFFF, 1'b1);
      add_row(KIND_DRAW, 8'h00, 3'd7, 8'hFF, 16'hFFF9, 16'hFFF9, 1'b1, 1,
              rsp_type'{32'd0, 8'hFF, 1'b1});
      add_row(KIND_DRAW, 8'hFF, 3'd0, 8'h00, 16'd639, 16'd479, 1'b1, 1,
              rsp_type'{32'd307199, 8'hFF, 1'b1});
      add_row(KIND_DRAW, 8'h00, 3'd3, 8'h5A, 16'd639, 16'hFFF9, 1'b1, 1,
              rsp_type'{32'd639, 8'h00, 1'b1});
      add_row(KIND_DRAW, 8'hFF, 3'd4, 8'hA5, 16'hFFF9, 16'd479, 1'b1, 1,
              rsp_type'{32'd306560, 8'h00, 1'b1});
      add_row(KIND_DRAW, 8'hFF, 3'd0, 8'h00, 16'h8000, 16'h8000, 1'b1, 0);
      add_row(KIND_DRAW, 8'hFF, 3'd7, 8'hFF, 16'h7FFF, 16'h7FFF, 1'b1, 0);
      add_row(KIND_DRAW, 8'h00, 3'd1, 8'h11, 16'd640, 16'd0, 1'b1, 0);
      add_row(KIND_DRAW, 8'h00, 3'd2, 8'h22, 16'd0, 16'd480, 1'b1, 0);
      add_row(KIND_DRAW, 8'hFF, 3'd6, 8'h66, 16'hFFF8, 16'hFFF8, 1'b1, 0);
      add_row(KIND_LOAD, 8'hFF, 3'd1, 8'h00, 16'd5, 16'd9);
      add_row(KIND_LOAD, 8'hFF, 3'd2, 8'hFF, 16'h1234, 16'hFEDC);
      add_row(KIND_LOAD, 8'hFF, 3'd3, 8'h55, 16'd0, 16'd0);
      add_row(KIND_LOAD, 8'hFF, 3'd4, 8'hAA, 16'd0, 16'd0);
      add_row(KIND_LOAD, 8'hFF, 3'd5, 8'h3C, 16'd0, 16'd0);
      add_row(KIND_LOAD, 8'hFF, 3'd6, 8'hC3, 16'd0, 16'd0);
      add_row(KIND_DRAW, 8'hFF, 3'd2, 8'h0F, 16'd0, 16'd0);
      add_row(KIND_DRAW, 8'hFF, 3'd5, 8'hF0, 16'd636, 16'd476);
      add_row(KIND_DRAW, 8'hFF, 3'd1, 8'h81, 16'hFFFC, 16'd3);
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed,
                   directed_rows[i].n_pix, directed_rows[i].pix);

      // Register settings for the random phases, extremes among them.
      l = int'($urandom_range(40)) - 20;
      t = int'($urandom_range(40)) - 20;
      plan[0] = '{16'(l), 16'(t), 16'(l + int'($urandom_range(9, 70))),
                  16'(t + int'($urandom_range(9, 40))), 8'($urandom), 8'($urandom),
                  16'($urandom_range(1, 65535)), $urandom};
      // widest window, maximal stride, base at the top of the address space
      plan[1] = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'h00, 8'hFF, 16'hFFFF,
                  32'hFFFF_FFFF};
      // window smaller than one cell, unit stride
      plan[2] = '{16'sd100, 16'sd50, 16'sd104, 16'sd53, 8'h5A, 8'hA5, 16'd1, 32'd0};
      // inverted window: every draw is clipped away
      plan[3] = '{16'sd200, 16'sd100, 16'sd100, 16'sd300, 8'($urandom), 8'($urandom),
                  16'd0, $urandom};
      l = -int'($urandom_range(20, 60));
      t = -int'($urandom_range(5, 30));
      plan[4] = '{16'(l), 16'(t), 16'(l + int'($urandom_range(20, 80))),
                  16'(t + int'($urandom_range(10, 40))), 8'($urandom), 8'($urandom),
                  16'd0, $urandom};
      // window at the negative end of the coordinate range
      plan[5] = '{16'h8000, 16'h8000, 16'h8014, 16'h800C, 8'hFF, 8'h00, 16'hFFFF, 32'd0};
      phase_items = '{80, 70, 70, 25, 80, 80};
      phase_gap   = '{35, 35, 49, 49, 0, 0};
      phase_stall = '{49, 49, 35, 35, 0, 0};

      for (p = 0; p < NUM_PHASES; p++) begin
         drain_results(SETTLE_CYCLES);
         apply_setting(plan[p]);
         gap_pct   = phase_gap[p];
         stall_pct = phase_stall[p];
         run_phase(phase_items[p]);
      end
      drain_results(SETTLE_CYCLES);

      $display("ran %0d glyph row loads and %0d draws (%0d fully clipped) over %0d settings",
               n_loads, n_draws, n_blank, NUM_PHASES + 1);
      $display("checked %0d pixel writes incl. wrapped addresses and zero stride, %0d bad",
               n_pixels, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/cgb_pkg.sv
hdl/cgb_ram.sv
hdl/clipped_glyph_blit_8bpp_unit.sv
bench/testbench.sv
